@@ src/aqah_pkg.sv @@
`default_nettype none

package aqah_pkg;

    // Alarm level codes
    localparam logic [1:0] LVL_NONE     = 2'd0;
    localparam logic [1:0] LVL_WARNING  = 2'd1;
    localparam logic [1:0] LVL_DANGER   = 2'd2;
    localparam logic [1:0] LVL_CRITICAL = 2'd3;

    // Cause codes
    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_AQI  = 2'd1;
    localparam logic [1:0] CAUSE_CO2  = 2'd2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_AQI_WARN_SET    = 3'd0,
        REG_AQI_WARN_CLR    = 3'd1,
        REG_AQI_DANGER_SET  = 3'd2,
        REG_AQI_DANGER_CLR  = 3'd3,
        REG_AQI_CRIT_SET    = 3'd4,
        REG_AQI_CRIT_CLR    = 3'd5,
        REG_CO2_WARNING_PPM = 3'd6,
        REG_CO2_DANGER_PPM  = 3'd7
    } reg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed limits and offsets
    localparam logic [15:0] AQI_LIMIT        = 16'd1000;
    localparam logic [16:0] CO2_LIMIT        = 17'd10000;
    localparam logic [16:0] AQI_JUMP         = 17'd50;
    localparam logic [16:0] CO2_JUMP         = 17'd300;
    localparam logic [16:0] CO2_CRIT_ON_ADD  = 17'd400;
    localparam logic [16:0] CO2_CRIT_OFF_ADD = 17'd300;
    localparam logic [16:0] CO2_OFF_SUB      = 17'd100;

    typedef struct packed {
        logic [15:0] aqi_warn_set;
        logic [15:0] aqi_warn_clr;
        logic [15:0] aqi_danger_set;
        logic [15:0] aqi_danger_clr;
        logic [15:0] aqi_crit_set;
        logic [15:0] aqi_crit_clr;
        logic [14:0] co2_warning_ppm;
        logic [14:0] co2_danger_ppm;
    } cfg_t;

    // What the tracker keeps from the previous sample
    typedef struct packed {
        logic [1:0]  level;
        logic [15:0] prev_aqi;
        logic [15:0] prev_co2;
    } hist_t;

    // Outcome of classifying one sample
    typedef struct packed {
        logic [1:0] level_next;
        logic [1:0] cause;
    } eval_t;

    typedef struct packed {
        logic        active;
        logic [1:0]  level;
        logic [1:0]  cause;
        logic [1:0]  peak_level;
        logic [31:0] activation_count;
        logic [31:0] active_tick_count;
        logic [31:0] warning_entries;
        logic [31:0] danger_entries;
        logic [31:0] critical_entries;
    } stat_t;

endpackage

`default_nettype wire

@@ src/air_quality_alarm_hysteresis.sv @@
// Air quality alarm with hysteresis. Each request on the slave side carries
// one AQI sample and one CO2 sample in ppm; each produces exactly one result
// request on the master side with the stored alarm level, the cause, the
// peak level and the wrapping statistics counters. The block takes one
// sample per clock cycle while results are taken: a sample is held in an
// input register, classified by a short stretch of compares and written
// into the result register, which also holds the alarm state and offers the
// result. While a result waits, one more sample is still taken into the
// input register; after that the slave side stalls until the result is
// taken. The user must write thresholds through the cfg port only while no
// sample is in flight; the block itself does not enforce it.
`default_nettype none

module air_quality_alarm_hysteresis (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,   // aqi[15:0], co2_ppm[31:16]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // active[0], level[2:1], cause[4:3], peak_level[6:5],
    // activation_count[38:7], active_tick_count[70:39], warning_entries[102:71],
    // danger_entries[134:103], critical_entries[166:135], zero[167]
    output logic [167:0]       m_axis_tdata,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_addr,
    input  wire logic [15:0]   cfg_wdata
);
    import aqah_pkg::*;

    cfg_t        cfg;
    hist_t       hist;
    eval_t       result;
    stat_t       stat;
    logic        in_valid_reg;
    logic [15:0] in_aqi_reg;
    logic [15:0] in_co2_reg;
    logic        out_valid_reg;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_aqi_reg <= s_axis_tdata[15:0];
            in_co2_reg <= s_axis_tdata[31:16];
        end
    end

    aqah_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aqah_eval u_eval (
        .aqi     (in_aqi_reg),
        .co2_ppm (in_co2_reg),
        .cfg     (cfg),
        .hist    (hist),
        .result  (result)
    );

    aqah_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .aqi     (in_aqi_reg),
        .co2_ppm (in_co2_reg),
        .result  (result),
        .hist    (hist),
        .stat    (stat)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            stat.critical_entries,
                            stat.danger_entries,
                            stat.warning_entries,
                            stat.active_tick_count,
                            stat.activation_count,
                            stat.peak_level,
                            stat.cause,
                            stat.level,
                            stat.active};

endmodule

`default_nettype wire

@@ src/aqah_cfg.sv @@
`default_nettype none

module aqah_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [aqah_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [aqah_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output aqah_pkg::cfg_t                       cfg
);
    import aqah_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.aqi_warn_set    <= 16'd100;
            cfg_reg.aqi_warn_clr    <= 16'd90;
            cfg_reg.aqi_danger_set  <= 16'd150;
            cfg_reg.aqi_danger_clr  <= 16'd130;
            cfg_reg.aqi_crit_set    <= 16'd250;
            cfg_reg.aqi_crit_clr    <= 16'd220;
            cfg_reg.co2_warning_ppm <= 15'd1000;
            cfg_reg.co2_danger_ppm  <= 15'd2000;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_AQI_WARN_SET:    cfg_reg.aqi_warn_set    <= cfg_wdata;
                REG_AQI_WARN_CLR:    cfg_reg.aqi_warn_clr    <= cfg_wdata;
                REG_AQI_DANGER_SET:  cfg_reg.aqi_danger_set  <= cfg_wdata;
                REG_AQI_DANGER_CLR:  cfg_reg.aqi_danger_clr  <= cfg_wdata;
                REG_AQI_CRIT_SET:    cfg_reg.aqi_crit_set    <= cfg_wdata;
                REG_AQI_CRIT_CLR:    cfg_reg.aqi_crit_clr    <= cfg_wdata;
                REG_CO2_WARNING_PPM: cfg_reg.co2_warning_ppm <= cfg_wdata[14:0];
                REG_CO2_DANGER_PPM:  cfg_reg.co2_danger_ppm  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/aqah_eval.sv @@
`default_nettype none

module aqah_eval (
    input  wire logic [15:0] aqi,
    input  wire logic [15:0] co2_ppm,
    input  aqah_pkg::cfg_t   cfg,
    input  aqah_pkg::hist_t  hist,
    output aqah_pkg::eval_t  result
);
    import aqah_pkg::*;

    logic [16:0] aqi_x;
    logic [16:0] co2_x;
    logic [16:0] warn_x;
    logic [16:0] danger_x;
    logic [1:0]  lvl_aqi;
    logic [1:0]  lvl_co2;
    logic [1:0]  cand;
    logic        aqi_jump;
    logic        co2_jump;
    logic        release_ok;

    assign aqi_x    = {1'b0, aqi};
    assign co2_x    = {1'b0, co2_ppm};
    assign warn_x   = {2'b00, cfg.co2_warning_ppm};
    assign danger_x = {2'b00, cfg.co2_danger_ppm};

    // The 17-bit sums cannot overflow, so every compare is exact.
    assign aqi_jump = (hist.prev_aqi != 16'd0) && (aqi_x > {1'b0, hist.prev_aqi} + AQI_JUMP);
    assign co2_jump = (hist.prev_co2 != 16'd0) && (co2_x > {1'b0, hist.prev_co2} + CO2_JUMP);

    always_comb
    begin
        if (aqi >= cfg.aqi_crit_set)
            lvl_aqi = LVL_CRITICAL;
        else if (aqi >= cfg.aqi_danger_set)
            lvl_aqi = LVL_DANGER;
        else if (aqi >= cfg.aqi_warn_set)
            lvl_aqi = LVL_WARNING;
        else
            lvl_aqi = LVL_NONE;

        if (co2_x >= danger_x + CO2_CRIT_ON_ADD)
            lvl_co2 = LVL_CRITICAL;
        else if (co2_x >= danger_x)
            lvl_co2 = LVL_DANGER;
        else if (co2_x >= warn_x)
            lvl_co2 = LVL_WARNING;
        else
            lvl_co2 = LVL_NONE;

        cand = (lvl_aqi > lvl_co2) ? lvl_aqi : lvl_co2;
        if ((aqi > AQI_LIMIT) || (co2_x > CO2_LIMIT))
            cand = LVL_CRITICAL;
        if ((aqi_jump || co2_jump) && (cand < LVL_DANGER))
            cand = LVL_DANGER;

        // A release threshold below zero can never be met; comparing
        // co2 + 100 against the threshold handles that without signs.
        case (hist.level)
            LVL_CRITICAL:
                release_ok = (aqi < cfg.aqi_crit_clr)
                             && (co2_x < danger_x + CO2_CRIT_OFF_ADD);
            LVL_DANGER:
                release_ok = (aqi < cfg.aqi_danger_clr)
                             && (co2_x + CO2_OFF_SUB < danger_x);
            LVL_WARNING:
                release_ok = (aqi < cfg.aqi_warn_clr)
                             && (co2_x + CO2_OFF_SUB < warn_x);
            default:
                release_ok = 1'b1;
        endcase

        result.level_next = ((cand > hist.level) || release_ok) ? cand : hist.level;
        result.cause      = ((lvl_aqi != LVL_NONE) ? CAUSE_AQI : CAUSE_NONE)
                          | ((lvl_co2 != LVL_NONE) ? CAUSE_CO2 : CAUSE_NONE);
    end

endmodule

`default_nettype wire

@@ src/aqah_track.sv @@
`default_nettype none

module aqah_track (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [15:0] aqi,
    input  wire logic [15:0] co2_ppm,
    input  aqah_pkg::eval_t  result,
    output aqah_pkg::hist_t  hist,
    output aqah_pkg::stat_t  stat
);
    import aqah_pkg::*;

    // The result register doubles as the alarm state: it only changes
    // when a sample moves into it.
    stat_t       stat_reg;
    stat_t       stat_next;
    logic [15:0] prev_aqi_reg;
    logic [15:0] prev_co2_reg;
    logic        changed;
    logic        now_active;

    always_comb
    begin
        changed    = (result.level_next != stat_reg.level);
        now_active = (result.level_next != LVL_NONE);
        stat_next  = stat_reg;

        stat_next.active     = now_active;
        stat_next.level      = result.level_next;
        stat_next.cause      = result.cause;
        stat_next.peak_level = (result.level_next > stat_reg.peak_level)
                               ? result.level_next : stat_reg.peak_level;

        if (now_active)
            stat_next.active_tick_count = stat_reg.active_tick_count + 32'd1;
        if (now_active && (stat_reg.level == LVL_NONE))
            stat_next.activation_count = stat_reg.activation_count + 32'd1;
        if (changed && (result.level_next == LVL_WARNING))
            stat_next.warning_entries = stat_reg.warning_entries + 32'd1;
        if (changed && (result.level_next == LVL_DANGER))
            stat_next.danger_entries = stat_reg.danger_entries + 32'd1;
        if (changed && (result.level_next == LVL_CRITICAL))
            stat_next.critical_entries = stat_reg.critical_entries + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg     <= '0;
            prev_aqi_reg <= 16'd0;
            prev_co2_reg <= 16'd0;
        end
        else if (advance)
        begin
            stat_reg     <= stat_next;
            prev_aqi_reg <= aqi;
            prev_co2_reg <= co2_ppm;
        end
    end

    assign hist.level    = stat_reg.level;
    assign hist.prev_aqi = prev_aqi_reg;
    assign hist.prev_co2 = prev_co2_reg;
    assign stat          = stat_reg;

endmodule

`default_nettype wire

@@ src/aqah_chk.sv @@
`default_nettype none

module aqah_chk (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [167:0] m_axis_tdata
);

    // The active flag must agree with the level it is reported with.
    a_active_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] != 2'd0)))
        else $error("active flag disagrees with level");

    // The peak can never sit below the current level.
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:5] >= m_axis_tdata[2:1]))
        else $error("peak level below current level");

    // With the result side empty the input side must never stall.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result request changed");

endmodule

bind air_quality_alarm_hysteresis aqah_chk u_aqah_chk (.*);

`default_nettype wire

@@ tb/alarm_checker.sv @@
`timescale 1ns / 100ps

module alarm_checker
    import aqah_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    input  logic           s_axis_tready,
    input  logic [31:0]    s_axis_tdata,   // aqi[15:0], co2_ppm[31:16]
    input  logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // active[0], level[2:1], cause[4:3], peak_level[6:5],
    // activation_count[38:7], active_tick_count[70:39], warning_entries[102:71],
    // danger_entries[134:103], critical_entries[166:135], zero[167]
    input  logic [167:0]   m_axis_tdata,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_addr,
    input  logic [15:0]    cfg_wdata,
    output int unsigned    in_flight,
    output int unsigned    faults
);

    localparam int AQI_RANGE_MAX  = 1000;
    localparam int CO2_RANGE_MAX  = 10000;
    localparam int AQI_STEP_MAX   = 50;
    localparam int CO2_STEP_MAX   = 300;
    localparam int CO2_CRIT_RISE  = 400;
    localparam int CO2_CRIT_FALL  = 300;
    localparam int CO2_FALL_BELOW = 100;

    typedef struct packed {
        logic [1:0]  level;
        logic [1:0]  cause;
        logic [1:0]  peak;
        logic [15:0] prior_aqi;
        logic [15:0] prior_co2;
        logic [31:0] activations;
        logic [31:0] ticks;
        logic [31:0] warn_in;
        logic [31:0] danger_in;
        logic [31:0] crit_in;
    } alarm_state_t;

    cfg_t         limits;
    alarm_state_t alarm;
    stat_t        pending_reports[$];
    stat_t        seen;
    stat_t        want;

    function automatic cfg_t power_on_limits();
        cfg_t t;
        t.aqi_warn_set    = 16'd100;
        t.aqi_warn_clr    = 16'd90;
        t.aqi_danger_set  = 16'd150;
        t.aqi_danger_clr  = 16'd130;
        t.aqi_crit_set    = 16'd250;
        t.aqi_crit_clr    = 16'd220;
        t.co2_warning_ppm = 15'd1000;
        t.co2_danger_ppm  = 15'd2000;
        return t;
    endfunction

    function automatic logic [1:0] aqi_grade(cfg_t t, logic [15:0] a);
        if (a >= t.aqi_crit_set) return LVL_CRITICAL;
        if (a >= t.aqi_danger_set) return LVL_DANGER;
        if (a >= t.aqi_warn_set) return LVL_WARNING;
        return LVL_NONE;
    endfunction

    function automatic logic [1:0] co2_grade(cfg_t t, logic [15:0] c);
        int ci;
        int dz;
        int wz;
        ci = int'(c);
        dz = int'(t.co2_danger_ppm);
        wz = int'(t.co2_warning_ppm);
        if (ci >= dz + CO2_CRIT_RISE) return LVL_CRITICAL;
        if (ci >= dz) return LVL_DANGER;
        if (ci >= wz) return LVL_WARNING;
        return LVL_NONE;
    endfunction

    // One sample through the classifier and the hysteresis tracker.
    function automatic alarm_state_t advance_alarm(alarm_state_t st, cfg_t t,
                                                   logic [15:0] a, logic [15:0] c);
        alarm_state_t nx;
        logic [1:0]   la;
        logic [1:0]   lc;
        logic [1:0]   cand;
        int           ai;
        int           ci;
        int           pa;
        int           pc;
        int           dz;
        int           wz;
        bit           drop;
        nx   = st;
        ai   = int'(a);
        ci   = int'(c);
        pa   = int'(st.prior_aqi);
        pc   = int'(st.prior_co2);
        dz   = int'(t.co2_danger_ppm);
        wz   = int'(t.co2_warning_ppm);
        la   = aqi_grade(t, a);
        lc   = co2_grade(t, c);
        cand = (la > lc) ? la : lc;
        nx.cause = {lc != LVL_NONE, la != LVL_NONE};

        if (ai > AQI_RANGE_MAX || ci > CO2_RANGE_MAX) cand = LVL_CRITICAL;
        if (pa != 0 && ai > pa + AQI_STEP_MAX && cand < LVL_DANGER) cand = LVL_DANGER;
        if (pc != 0 && ci - pc > CO2_STEP_MAX && cand < LVL_DANGER) cand = LVL_DANGER;

        // The CO2 release points are signed, so a low threshold can never release.
        case (st.level)
            LVL_CRITICAL: drop = ai < int'(t.aqi_crit_clr) && ci < dz + CO2_CRIT_FALL;
            LVL_DANGER:   drop = ai < int'(t.aqi_danger_clr) && ci < dz - CO2_FALL_BELOW;
            LVL_WARNING:  drop = ai < int'(t.aqi_warn_clr) && ci < wz - CO2_FALL_BELOW;
            default:      drop = 1'b1;
        endcase
        if (cand > st.level || drop) nx.level = cand;
        if (nx.level > nx.peak) nx.peak = nx.level;

        if (nx.level != st.level) begin
            case (nx.level)
                LVL_WARNING:  nx.warn_in   = nx.warn_in + 32'd1;
                LVL_DANGER:   nx.danger_in = nx.danger_in + 32'd1;
                LVL_CRITICAL: nx.crit_in   = nx.crit_in + 32'd1;
                default:      ;
            endcase
        end
        if (nx.level != LVL_NONE) nx.ticks = nx.ticks + 32'd1;
        if (st.level == LVL_NONE && nx.level != LVL_NONE)
            nx.activations = nx.activations + 32'd1;

        nx.prior_aqi = a;
        nx.prior_co2 = c;
        return nx;
    endfunction

    function automatic stat_t report_of(alarm_state_t st);
        stat_t r;
        r.active            = (st.level != LVL_NONE);
        r.level             = st.level;
        r.cause             = st.cause;
        r.peak_level        = st.peak;
        r.activation_count  = st.activations;
        r.active_tick_count = st.ticks;
        r.warning_entries   = st.warn_in;
        r.danger_entries    = st.danger_in;
        r.critical_entries  = st.crit_in;
        return r;
    endfunction

    function automatic stat_t unpack_report(logic [167:0] d);
        stat_t r;
        r.active            = d[0];
        r.level             = d[2:1];
        r.cause             = d[4:3];
        r.peak_level        = d[6:5];
        r.activation_count  = d[38:7];
        r.active_tick_count = d[70:39];
        r.warning_entries   = d[102:71];
        r.danger_entries    = d[134:103];
        r.critical_entries  = d[166:135];
        return r;
    endfunction

    function automatic bit report_differs(stat_t x, stat_t y);
        return x.active !== y.active || x.level !== y.level || x.cause !== y.cause ||
               x.peak_level !== y.peak_level ||
               x.activation_count !== y.activation_count ||
               x.active_tick_count !== y.active_tick_count ||
               x.warning_entries !== y.warning_entries ||
               x.danger_entries !== y.danger_entries ||
               x.critical_entries !== y.critical_entries;
    endfunction

    task automatic show_report(string tag, stat_t r);
        $display("  %s act=%0d lvl=%0d cause=%0d peak=%0d acts=%0d ticks=%0d w=%0d d=%0d c=%0d",
                 tag, r.active, r.level, r.cause, r.peak_level, r.activation_count,
                 r.active_tick_count, r.warning_entries, r.danger_entries,
                 r.critical_entries);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limits    = power_on_limits();
            alarm     = '0;
            pending_reports.delete();
            faults    = 0;
            in_flight <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_AQI_WARN_SET:    limits.aqi_warn_set    = cfg_wdata;
                    REG_AQI_WARN_CLR:    limits.aqi_warn_clr    = cfg_wdata;
                    REG_AQI_DANGER_SET:  limits.aqi_danger_set  = cfg_wdata;
                    REG_AQI_DANGER_CLR:  limits.aqi_danger_clr  = cfg_wdata;
                    REG_AQI_CRIT_SET:    limits.aqi_crit_set    = cfg_wdata;
                    REG_AQI_CRIT_CLR:    limits.aqi_crit_clr    = cfg_wdata;
                    REG_CO2_WARNING_PPM: limits.co2_warning_ppm = cfg_wdata[14:0];
                    REG_CO2_DANGER_PPM:  limits.co2_danger_ppm  = cfg_wdata[14:0];
                    default:             ;
                endcase
            end

            // Results are taken before new samples, so a request accepted on this
            // edge can never be matched against a result leaving on the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                seen = unpack_report(m_axis_tdata);
                if (pending_reports.size() == 0) begin
                    if (faults < 10) begin
                        $display("unexpected result at %0t", $realtime);
                        show_report("actual  ", seen);
                    end
                    faults++;
                end
                else begin
                    want = pending_reports.pop_front();
                    if (report_differs(want, seen)) begin
                        if (faults < 10) begin
                            $display("result mismatch at %0t", $realtime);
                            show_report("expected", want);
                            show_report("actual  ", seen);
                        end
                        faults++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                alarm = advance_alarm(alarm, limits, s_axis_tdata[15:0], s_axis_tdata[31:16]);
                pending_reports.push_back(report_of(alarm));
            end

            in_flight <= unsigned'(pending_reports.size());
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import aqah_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_SAMPLES = 200;
    localparam int PHASES        = 7;
    localparam int HOLD_CYCLES   = 120;
    localparam int DIRECTED_N    = 24;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [31:0]    s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [167:0]   m_axis_tdata;
    logic           cfg_we;
    logic [2:0]     cfg_addr;
    logic [15:0]    cfg_wdata;

    int unsigned    in_flight;
    int unsigned    faults;
    int unsigned    cycles = 0;
    int unsigned    sent = 0;
    int unsigned    settings = 0;
    int unsigned    hold_req = 0;
    int unsigned    hold_seen = 0;
    logic           steady;
    cfg_t           cur;
    logic [15:0]    last_a;
    logic [15:0]    last_c;

    // Edges of the level map, the jump rules and the out-of-range limits.
    int unsigned dir_aqi[DIRECTED_N] = '{0, 100, 95, 89, 0, 0, 0, 0, 1001, 1000,
                                         0, 0, 0, 65535, 200, 260, 219, 210, 0, 51,
                                         102, 0, 65535, 0};
    int unsigned dir_co2[DIRECTED_N] = '{0, 0, 0, 0, 1000, 899, 1300, 1300, 0, 10000,
                                         10001, 2400, 2399, 65535, 2000, 0, 2299, 2250,
                                         0, 0, 0, 65535, 0, 0};

    air_quality_alarm_hysteresis dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    alarm_checker alarm_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_flight     (in_flight),
        .faults        (faults)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles, in_flight);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, or a long hold when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    function automatic logic [15:0] clip16(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic cfg_t thresholds_for(int unsigned ph);
        cfg_t t;
        int   w;
        int   d;
        int   k;
        case (ph)
            0, 6:
            begin
                t.aqi_warn_set    = 16'd100;
                t.aqi_warn_clr    = 16'd90;
                t.aqi_danger_set  = 16'd150;
                t.aqi_danger_clr  = 16'd130;
                t.aqi_crit_set    = 16'd250;
                t.aqi_crit_clr    = 16'd220;
                t.co2_warning_ppm = 15'd1000;
                t.co2_danger_ppm  = 15'd2000;
            end
            1: t = '0;
            2: t = '1;
            3:
            begin
                // Misordered on purpose: every threshold drawn on its own.
                t.aqi_warn_set    = 16'($urandom_range(0, 1200));
                t.aqi_warn_clr    = 16'($urandom_range(0, 1200));
                t.aqi_danger_set  = 16'($urandom_range(0, 1200));
                t.aqi_danger_clr  = 16'($urandom_range(0, 1200));
                t.aqi_crit_set    = 16'($urandom_range(0, 1200));
                t.aqi_crit_clr    = 16'($urandom_range(0, 1200));
                t.co2_warning_ppm = 15'($urandom_range(0, 12000));
                t.co2_danger_ppm  = 15'($urandom_range(0, 12000));
            end
            default:
            begin
                w = $urandom_range(20, 400);
                d = w + $urandom_range(1, 200);
                k = d + $urandom_range(1, 300);
                t.aqi_warn_set    = 16'(w);
                t.aqi_warn_clr    = 16'($urandom_range(0, w));
                t.aqi_danger_set  = 16'(d);
                t.aqi_danger_clr  = 16'($urandom_range(0, d));
                t.aqi_crit_set    = 16'(k);
                t.aqi_crit_clr    = 16'($urandom_range(0, k));
                // One setting draws the CO2 warning point from a range reaching below the release offset.
                w = (ph == 5) ? $urandom_range(0, 150) : $urandom_range(200, 3000);
                d = w + $urandom_range(0, (ph == 5) ? 9000 : 3000);
                t.co2_warning_ppm = 15'(w);
                t.co2_danger_ppm  = 15'(d);
            end
        endcase
        return t;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // The top bit of the CO2 writes is random: the block must drop it.
    task automatic load_thresholds(input cfg_t t);
        write_reg(REG_AQI_WARN_SET, t.aqi_warn_set);
        write_reg(REG_AQI_WARN_CLR, t.aqi_warn_clr);
        write_reg(REG_AQI_DANGER_SET, t.aqi_danger_set);
        write_reg(REG_AQI_DANGER_CLR, t.aqi_danger_clr);
        write_reg(REG_AQI_CRIT_SET, t.aqi_crit_set);
        write_reg(REG_AQI_CRIT_CLR, t.aqi_crit_clr);
        write_reg(REG_CO2_WARNING_PPM, {1'($urandom_range(0, 1)), t.co2_warning_ppm});
        write_reg(REG_CO2_DANGER_PPM, {1'($urandom_range(0, 1)), t.co2_danger_ppm});
        cfg_we <= 1'b0;
        cur = t;
        settings++;
    endtask

    task automatic send_sample(input logic [15:0] a, input logic [15:0] c);
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, a};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        last_a = a;
        last_c = c;
        sent++;
    endtask

    // Waits for the next edge first so that a request taken on the last edge is counted.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Mostly a walk from the last sample, so the hysteresis is worked through
    // rise and release; the rest sits on the thresholds, drops to zero, is plain noise or sits at the range limits.
    task automatic pick_sample(output logic [15:0] a, output logic [15:0] c);
        int r;
        int va;
        int vc;
        int da;
        int dc;
        va = int'(last_a);
        vc = int'(last_c);
        da = $urandom_range(0, 120);
        dc = $urandom_range(0, 700);
        r  = $urandom_range(0, 99);
        if (r < 55)
        begin
            va = va + da - 60;
            vc = vc + dc - 350;
        end
        else if (r < 75)
        begin
            case ($urandom_range(0, 5))
                0: va = int'(cur.aqi_warn_set);
                1: va = int'(cur.aqi_warn_clr);
                2: va = int'(cur.aqi_danger_set);
                3: va = int'(cur.aqi_danger_clr);
                4: va = int'(cur.aqi_crit_set);
                default: va = int'(cur.aqi_crit_clr);
            endcase
            case ($urandom_range(0, 5))
                0: vc = int'(cur.co2_warning_ppm);
                1: vc = int'(cur.co2_warning_ppm) - 100;
                2: vc = int'(cur.co2_danger_ppm);
                3: vc = int'(cur.co2_danger_ppm) - 100;
                4: vc = int'(cur.co2_danger_ppm) + 300;
                default: vc = int'(cur.co2_danger_ppm) + 400;
            endcase
            va = va + $urandom_range(0, 6) - 3;
            vc = vc + $urandom_range(0, 6) - 3;
        end
        else if (r < 83)
        begin
            va = ($urandom_range(0, 1) != 0) ? 0 : va + da - 60;
            vc = ($urandom_range(0, 1) != 0) ? 0 : vc + dc - 350;
        end
        else if (r < 93)
        begin
            va = $urandom_range(0, 65535);
            vc = $urandom_range(0, 65535);
        end
        else
        begin
            va = 999 + $urandom_range(0, 3);
            vc = 9999 + $urandom_range(0, 3);
        end
        a = clip16(va);
        c = clip16(vc);
    endtask

    initial
    begin
        logic [15:0]  a;
        logic [15:0]  c;
        int unsigned  ph;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_AQI_WARN_SET;
        cfg_wdata     = '0;
        steady        = 1'b0;
        cur           = thresholds_for(0);
        last_a        = '0;
        last_c        = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-on thresholds are still in force for the directed samples.
        for (int i = 0; i < DIRECTED_N; i++)
            send_sample(16'(dir_aqi[i]), 16'(dir_co2[i]));

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            load_thresholds(thresholds_for(ph));
            steady <= (ph == PHASES - 1);
            if (ph == 3)
                hold_req <= hold_req + 1;
            repeat (PHASE_SAMPLES)
            begin
                pick_sample(a, c);
                send_sample(a, c);
            end
        end

        drain_results();
        $display("%0d samples over %0d threshold settings (zero, full scale, misordered),",
                 sent, settings);
        $display("with a long result hold, drain pauses and a stretch free of idling.");
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
